FILE: src/pcs_pkg.sv
// ----------------------------------------------------------------------------
// pcs_pkg
// Shared types and constants for the prefer-idle CPU selector: the item and
// result payloads and the candidate record passed from classifier to tracker.
// ----------------------------------------------------------------------------
package pcs_pkg;

    // fixed field widths
    localparam int CPU_W  = 3;
    localparam int UTIL_W = 12;
    localparam int NEED_W = UTIL_W + 1;

    localparam logic [NEED_W-1:0] NEED_ONES = {NEED_W{1'b1}};

    // one status item per cpu
    typedef struct packed {
        logic [CPU_W-1:0]  cpu_id;
        logic              allowed;
        logic              online;
        logic              is_idle;
        logic [UTIL_W-1:0] base_util;
        logic [UTIL_W-1:0] capacity;
        logic [UTIL_W-1:0] task_load;
        logic [UTIL_W-1:0] floor_util;
        logic [CPU_W-1:0]  home_cpu;
        logic              group_end;
        logic              domain_end;
    } t_item;

    // selection result, one per request
    typedef struct packed {
        logic             found;
        logic [CPU_W-1:0] target;
    } t_result;

    // classified candidate for the tracker
    typedef struct packed {
        logic              usable;
        logic              overcap_idle;
        logic              fit_idle;
        logic              fit_busy;
        logic              is_home;
        logic [NEED_W-1:0] need;
        logic [CPU_W-1:0]  cpu;
        logic [CPU_W-1:0]  home;
        logic              group_end;
        logic              domain_end;
    } t_cand;

endpackage

FILE: src/pcs_classify.sv
// ----------------------------------------------------------------------------
// pcs_classify
// Computes the needed utilization of one cpu and sorts it into overcap idle,
// fitting idle, fitting busy or skipped; an overcap busy cpu is skipped too.
// ----------------------------------------------------------------------------
module pcs_classify #(
    parameter int NUM_CPUS = 8
) (
    input  pcs_pkg::t_item i_item,
    output pcs_pkg::t_cand o_cand
);

    logic [pcs_pkg::NEED_W-1:0] sum;
    logic [pcs_pkg::NEED_W-1:0] floor_ext;
    logic [pcs_pkg::NEED_W-1:0] need;
    logic                       in_range;
    logic                       usable;
    logic                       overcap;

    // need = max(floor, base + task), one bit wider so the sum cannot wrap
    assign sum       = {1'b0, i_item.base_util} + {1'b0, i_item.task_load};
    assign floor_ext = {1'b0, i_item.floor_util};
    assign need      = (floor_ext > sum) ? floor_ext : sum;

    // skip cpus that are not allowed, offline or beyond the domain
    assign in_range = (int'(i_item.cpu_id) < NUM_CPUS);
    assign usable   = i_item.allowed && i_item.online && in_range;
    assign overcap  = need > {1'b0, i_item.capacity};

    // candidate record
    always_comb begin
        o_cand.usable       = usable;
        o_cand.overcap_idle = usable && overcap && i_item.is_idle;
        o_cand.fit_idle     = usable && !overcap && i_item.is_idle;
        o_cand.fit_busy     = usable && !overcap && !i_item.is_idle;
        o_cand.is_home      = (i_item.cpu_id == i_item.home_cpu);
        o_cand.need         = need;
        o_cand.cpu          = i_item.cpu_id;
        o_cand.home         = i_item.home_cpu;
        o_cand.group_end    = i_item.group_end;
        o_cand.domain_end   = i_item.domain_end;
    end

endmodule

FILE: src/pcs_tracker.sv
// ----------------------------------------------------------------------------
// pcs_tracker
// Keeps the running best candidates of a request, settles the pick at group
// and domain ends and holds the result in an output register.
// ----------------------------------------------------------------------------
module pcs_tracker (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  pcs_pkg::t_cand   i_cand,
    output logic             o_take,
    output logic             o_valid,
    output pcs_pkg::t_result o_result,
    input  logic             i_ready
);

    logic                       r_decided;
    logic [pcs_pkg::CPU_W-1:0]  r_chosen;
    logic                       r_busy_valid;
    logic [pcs_pkg::CPU_W-1:0]  r_busy_cpu;
    logic [pcs_pkg::NEED_W-1:0] r_busy_util;
    logic                       r_idle_seen;
    logic [pcs_pkg::CPU_W-1:0]  r_idle_pick;
    logic [pcs_pkg::NEED_W-1:0] r_idle_util;
    logic                       r_oc_seen;
    logic                       r_oc_home;
    logic [pcs_pkg::CPU_W-1:0]  r_oc_cpu;
    logic [pcs_pkg::NEED_W-1:0] r_oc_util;
    logic                       r_out_valid;
    pcs_pkg::t_result           r_out;

    logic                       n_decided;
    logic [pcs_pkg::CPU_W-1:0]  n_chosen;
    logic                       n_busy_valid;
    logic [pcs_pkg::CPU_W-1:0]  n_busy_cpu;
    logic [pcs_pkg::NEED_W-1:0] n_busy_util;
    logic                       n_idle_seen;
    logic [pcs_pkg::CPU_W-1:0]  n_idle_pick;
    logic [pcs_pkg::NEED_W-1:0] n_idle_util;
    logic                       n_oc_seen;
    logic                       n_oc_home;
    logic [pcs_pkg::CPU_W-1:0]  n_oc_cpu;
    logic [pcs_pkg::NEED_W-1:0] n_oc_util;
    pcs_pkg::t_result           n_out;

    logic step;
    logic finish;

    // an item that closes the request needs room in the result register
    assign o_take = !i_cand.domain_end || !r_out_valid || i_ready;
    assign step   = i_valid && o_take;
    assign finish = step && i_cand.domain_end;

    // candidate update, then group end pick, then result
    always_comb begin
        n_decided    = r_decided;
        n_chosen     = r_chosen;
        n_busy_valid = r_busy_valid;
        n_busy_cpu   = r_busy_cpu;
        n_busy_util  = r_busy_util;
        n_idle_seen  = r_idle_seen;
        n_idle_pick  = r_idle_pick;
        n_idle_util  = r_idle_util;
        n_oc_seen    = r_oc_seen;
        n_oc_home    = r_oc_home;
        n_oc_cpu     = r_oc_cpu;
        n_oc_util    = r_oc_util;

        if (!r_decided) begin
            if (i_cand.overcap_idle) begin
                n_oc_seen = 1'b1;
                if (i_cand.is_home) begin
                    n_oc_home = 1'b1;
                end
                if (i_cand.need < r_oc_util) begin
                    n_oc_util = i_cand.need;
                    n_oc_cpu  = i_cand.cpu;
                end
            end else if (i_cand.fit_idle) begin
                if (i_cand.is_home) begin
                    n_decided = 1'b1;
                    n_chosen  = i_cand.cpu;
                end else begin
                    n_idle_seen = 1'b1;
                    if (i_cand.need < r_idle_util) begin
                        n_idle_util = i_cand.need;
                        n_idle_pick = i_cand.cpu;
                    end
                end
            end else if (i_cand.fit_busy && (i_cand.need < r_busy_util)) begin
                n_busy_util  = i_cand.need;
                n_busy_cpu   = i_cand.cpu;
                n_busy_valid = 1'b1;
            end
        end

        if (!n_decided && (i_cand.group_end || i_cand.domain_end)) begin
            if (n_idle_seen) begin
                n_decided = 1'b1;
                n_chosen  = n_idle_pick;
            end else if (n_busy_valid) begin
                n_decided = 1'b1;
                n_chosen  = n_busy_cpu;
            end
        end

        if (n_decided) begin
            n_out.found  = 1'b1;
            n_out.target = n_chosen;
        end else if (n_oc_seen) begin
            n_out.found  = 1'b1;
            n_out.target = n_oc_home ? i_cand.home : n_oc_cpu;
        end else begin
            n_out.found  = 1'b0;
            n_out.target = '0;
        end
    end

    // request state, cleared at reset and after every domain end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || finish) begin
            r_decided    <= 1'b0;
            r_chosen     <= '0;
            r_busy_valid <= 1'b0;
            r_busy_cpu   <= '0;
            r_busy_util  <= pcs_pkg::NEED_ONES;
            r_idle_seen  <= 1'b0;
            r_idle_pick  <= '0;
            r_idle_util  <= pcs_pkg::NEED_ONES;
            r_oc_seen    <= 1'b0;
            r_oc_home    <= 1'b0;
            r_oc_cpu     <= '0;
            r_oc_util    <= pcs_pkg::NEED_ONES;
        end else if (step) begin
            r_decided    <= n_decided;
            r_chosen     <= n_chosen;
            r_busy_valid <= n_busy_valid;
            r_busy_cpu   <= n_busy_cpu;
            r_busy_util  <= n_busy_util;
            r_idle_seen  <= n_idle_seen;
            r_idle_pick  <= n_idle_pick;
            r_idle_util  <= n_idle_util;
            r_oc_seen    <= n_oc_seen;
            r_oc_home    <= n_oc_home;
            r_oc_cpu     <= n_oc_cpu;
            r_oc_util    <= n_oc_util;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (finish) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_out <= n_out;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

`ifndef NO_ASSERTIONS
    // a running best carries a real need exactly when its flag is set
    a_busy_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy_valid == (r_busy_util != pcs_pkg::NEED_ONES))
        else $error("busy best flag and need disagree");

    a_idle_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idle_seen == (r_idle_util != pcs_pkg::NEED_ONES))
        else $error("idle best flag and need disagree");

    a_oc_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_oc_seen == (r_oc_util != pcs_pkg::NEED_ONES))
        else $error("overcap best flag and need disagree");

    // a closed request leaves no pick behind and raises a result
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        finish |=> !r_decided && !r_idle_seen && !r_oc_seen && r_out_valid)
        else $error("request state not cleared after domain end");

    // an empty result names cpu zero
    a_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.found) |-> (r_out.target == '0))
        else $error("empty result with nonzero target");
`endif

endmodule

FILE: src/prefer_idle_cpu_select.sv
// ----------------------------------------------------------------------------
// prefer_idle_cpu_select
// Picks a target cpu for a waking task from a stream of per-cpu status items.
// ----------------------------------------------------------------------------
// Usage: software sends one t_item per cpu on i_valid/o_ready, in domain
// order and grouped by cluster, marking the last cpu of a cluster with
// group_end and the last item of the request with domain_end. Exactly one
// t_result transfer follows each domain_end item on o_valid/i_ready.
// Path: an item is captured in the input register at its transfer; the
// classifier and tracker then fold it into the running bests, and a
// domain_end item loads the result register as it leaves the input register.
// Throughput: one item per cycle unless a domain_end item is held; the only
// loop is the update of the tracker's running minima.
// Stall: the input register moves on while a result waits, except a
// domain_end item, which holds until the result register is free. o_ready
// then drops once the input register is also full.
// Reset: synchronous, active low; clears the input and result valid flags and
// all request state, so the next item starts a fresh request.
// ----------------------------------------------------------------------------
module prefer_idle_cpu_select #(
    parameter int NUM_CPUS = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  pcs_pkg::t_item   i_item,
    output logic             o_valid,
    input  logic             i_ready,
    output pcs_pkg::t_result o_result
);

    logic           r_in_valid;
    pcs_pkg::t_item r_in;
    pcs_pkg::t_cand cand;
    logic           take;
    logic           accept;

    // input register
    assign o_ready = !r_in_valid || take;
    assign accept  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (take) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_item;
        end
    end

    // classify the held item
    pcs_classify #(
        .NUM_CPUS (NUM_CPUS)
    ) u_classify (
        .i_item (r_in),
        .o_cand (cand)
    );

    // running bests and result register
    pcs_tracker u_tracker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_in_valid),
        .i_cand   (cand),
        .o_take   (take),
        .o_valid  (o_valid),
        .o_result (o_result),
        .i_ready  (i_ready)
    );

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for prefer_idle_cpu_select. A directed set of requests
// walks the selection rules (home pick, idle and busy fallbacks, overcap
// fallback, ties, skipped cpus), then random requests follow, most of them
// well formed and some broken. A scoreboard predicts the pick of each request
// and compares every result transfer in order.
// ----------------------------------------------------------------------------
module testbench;

    localparam int          CPU_COUNT   = 8;
    localparam int          ITEM_TARGET = 1950;
    localparam int unsigned CYCLE_LIMIT = 200000;

    localparam int CPU_W  = pcs_pkg::CPU_W;
    localparam int UTIL_W = pcs_pkg::UTIL_W;
    localparam int NEED_W = pcs_pkg::NEED_W;

    // scoreboard: predicted picks per request, checked in order
    class pick_scoreboard;
        pcs_pkg::t_result  picks_due[$];
        int unsigned       mismatches;
        bit                decided;
        logic [CPU_W-1:0]  chosen;
        bit                busy_valid;
        logic [CPU_W-1:0]  busy_cpu;
        logic [NEED_W-1:0] busy_need;
        bit                idle_valid;
        logic [CPU_W-1:0]  idle_pick;
        logic [NEED_W-1:0] idle_need;
        bit                over_valid;
        bit                over_home;
        logic [CPU_W-1:0]  over_cpu;
        logic [NEED_W-1:0] over_need;

        function new();
            mismatches = 0;
            clear_request();
        endfunction

        function void clear_request();
            decided    = 1'b0;
            chosen     = '0;
            busy_valid = 1'b0;
            busy_cpu   = '0;
            busy_need  = pcs_pkg::NEED_ONES;
            idle_valid = 1'b0;
            idle_pick  = '0;
            idle_need  = pcs_pkg::NEED_ONES;
            over_valid = 1'b0;
            over_home  = 1'b0;
            over_cpu   = '0;
            over_need  = pcs_pkg::NEED_ONES;
        endfunction

        function int pending();
            return picks_due.size();
        endfunction

        // fold one accepted item into the request state
        function void note_item(pcs_pkg::t_item it);
            logic [NEED_W-1:0] need;
            pcs_pkg::t_result  pick;
            if (!decided && it.allowed && it.online && int'(it.cpu_id) < CPU_COUNT) begin
                need = {1'b0, it.base_util} + {1'b0, it.task_load};
                if ({1'b0, it.floor_util} > need) begin
                    need = {1'b0, it.floor_util};
                end
                if (need > {1'b0, it.capacity}) begin
                    if (it.is_idle) begin
                        over_valid = 1'b1;
                        if (it.cpu_id == it.home_cpu) begin
                            over_home = 1'b1;
                        end
                        if (need < over_need) begin
                            over_need = need;
                            over_cpu  = it.cpu_id;
                        end
                    end
                end else if (it.is_idle) begin
                    // a fitting idle home cpu settles the request
                    if (it.cpu_id == it.home_cpu) begin
                        decided = 1'b1;
                        chosen  = it.cpu_id;
                    end else begin
                        idle_valid = 1'b1;
                        if (need < idle_need) begin
                            idle_need = need;
                            idle_pick = it.cpu_id;
                        end
                    end
                end else if (need < busy_need) begin
                    busy_need  = need;
                    busy_cpu   = it.cpu_id;
                    busy_valid = 1'b1;
                end
            end

            // cluster close: idle fit first, then busy fit
            if (!decided && (it.group_end || it.domain_end)) begin
                if (idle_valid) begin
                    decided = 1'b1;
                    chosen  = idle_pick;
                end else if (busy_valid) begin
                    decided = 1'b1;
                    chosen  = busy_cpu;
                end
            end

            if (it.domain_end) begin
                pick = '0;
                if (decided) begin
                    pick.found  = 1'b1;
                    pick.target = chosen;
                end else if (over_valid) begin
                    pick.found  = 1'b1;
                    pick.target = over_home ? it.home_cpu : over_cpu;
                end
                picks_due.push_back(pick);
                clear_request();
            end
        endfunction

        function void flag_mismatch(string what, pcs_pkg::t_result want,
                                    pcs_pkg::t_result got);
            mismatches++;
            if (mismatches <= 10) begin
                $display("%0t: pick mismatch (%s): expected found=%0b target=%0d,",
                         $realtime, what, want.found, want.target,
                         " got found=%0b target=%0d", got.found, got.target);
            end
        endfunction

        // compare one result transfer with the oldest prediction
        function void check_pick(pcs_pkg::t_result got);
            pcs_pkg::t_result want;
            if (picks_due.size() == 0) begin
                flag_mismatch("no pick pending", '0, got);
                return;
            end
            want = picks_due.pop_front();
            if (got.found !== want.found || got.target !== want.target) begin
                flag_mismatch("wrong pick", want, got);
            end
        endfunction
    endclass

    typedef enum int {RX_FLOW, RX_CHOPPY, RX_HOLD} t_rx_mode;

    logic             i_clk   = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_valid = 1'b0;
    logic             o_ready;
    pcs_pkg::t_item   i_item  = '0;
    logic             o_valid;
    logic             i_ready = 1'b0;
    pcs_pkg::t_result o_result;

    pick_scoreboard sb = new();
    int          items_sent  = 0;
    int          burst_left  = 0;
    int unsigned cycle_count = 0;
    t_rx_mode    rx_mode     = RX_FLOW;
    int          rx_run      = 0;

    prefer_idle_cpu_select #(
        .NUM_CPUS (CPU_COUNT)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (o_result)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // result side: check each transfer, stall in runs of flow, chop and hold
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            sb.check_pick(o_result);
        end
        if (rx_run == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 2));
            rx_run  = (rx_mode == RX_HOLD) ? $urandom_range(1, 12) : $urandom_range(1, 30);
        end
        rx_run--;
        case (rx_mode)
            RX_FLOW: begin
                i_ready <= 1'b1;
            end
            RX_CHOPPY: begin
                i_ready <= 1'($urandom_range(0, 1));
            end
            default: begin
                i_ready <= 1'b0;
            end
        endcase
    end

    function automatic pcs_pkg::t_item make_item(int cpu, int allowed, int online, int idle,
                                                 int base, int cap, int tload, int flr,
                                                 int home, int gend, int dend);
        pcs_pkg::t_item it;
        it.cpu_id     = CPU_W'(cpu);
        it.allowed    = 1'(allowed);
        it.online     = 1'(online);
        it.is_idle    = 1'(idle);
        it.base_util  = UTIL_W'(base);
        it.capacity   = UTIL_W'(cap);
        it.task_load  = UTIL_W'(tload);
        it.floor_util = UTIL_W'(flr);
        it.home_cpu   = CPU_W'(home);
        it.group_end  = 1'(gend);
        it.domain_end = 1'(dend);
        return it;
    endfunction

    // utilization with weight on the extremes and on small values
    function automatic logic [UTIL_W-1:0] rand_util();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2, 3, 4: return UTIL_W'($urandom_range(0, 511));
            default: return UTIL_W'($urandom);
        endcase
    endfunction

    // present one item and hold it until the transfer; bursts with random gaps
    task automatic send_item(input pcs_pkg::t_item it);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap        = $urandom_range(0, 8);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid <= 1'b1;
        i_item  <= it;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_item(it);
        items_sent++;
    endtask

    // hold off the sender until every pick is back
    task automatic drain_picks();
        i_valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // one request: ascending cpus in random clusters, or a broken one
    task automatic send_request(input bit noisy);
        logic [CPU_COUNT-1:0] cpu_mask;
        logic [63:0]          raw;
        logic [UTIL_W-1:0]    tload;
        logic [UTIL_W-1:0]    flr;
        logic [CPU_W-1:0]     home;
        int                   last_cpu;
        pcs_pkg::t_item       it;
        cpu_mask = CPU_COUNT'($urandom_range(1, 255));
        if ($urandom_range(0, 7) == 0) begin
            cpu_mask = CPU_COUNT'(1 << $urandom_range(0, CPU_COUNT - 1));
        end
        last_cpu = 0;
        for (int c = 0; c < CPU_COUNT; c++) begin
            if (cpu_mask[c]) last_cpu = c;
        end
        tload = rand_util();
        flr   = $urandom_range(0, 1) ? '0 : rand_util();
        home  = CPU_W'($urandom_range(0, CPU_COUNT - 1));
        for (int c = 0; c < CPU_COUNT; c++) begin
            if (cpu_mask[c]) begin
                if (noisy) begin
                    // any content, only the request end kept in place
                    raw           = {$urandom, $urandom};
                    it            = raw[$bits(pcs_pkg::t_item)-1:0];
                    it.domain_end = (c == last_cpu);
                end else begin
                    it.cpu_id     = CPU_W'(c);
                    it.allowed    = ($urandom_range(0, 9) != 0);
                    it.online     = ($urandom_range(0, 9) != 0);
                    it.is_idle    = 1'($urandom_range(0, 1));
                    it.base_util  = rand_util();
                    it.capacity   = rand_util();
                    it.task_load  = tload;
                    it.floor_util = flr;
                    it.home_cpu   = home;
                    it.group_end  = (c == last_cpu) || ($urandom_range(0, 2) == 0);
                    it.domain_end = (c == last_cpu);
                end
                send_item(it);
            end
        end
    endtask

    // stimulus and end of run
    initial begin
        bit drained_mid;
        drained_mid = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // idle home cpu that fits wins, the rest of the request is ignored
        send_item(make_item(1, 1, 1, 1, 0, 0, 0, 0, 1, 0, 0));
        send_item(make_item(2, 1, 1, 1, 0, 4095, 0, 0, 1, 1, 1));
        // full-scale sum overcaps, skipped cpus, request end without cluster end
        send_item(make_item(0, 1, 1, 1, 4095, 4095, 4095, 0, 7, 0, 0));
        send_item(make_item(3, 0, 1, 1, 0, 4095, 0, 0, 7, 1, 0));
        send_item(make_item(5, 1, 0, 1, 0, 4095, 0, 0, 7, 0, 1));
        // overcap home fallback reports the home of the closing item
        send_item(make_item(4, 1, 1, 1, 100, 50, 0, 0, 4, 0, 0));
        send_item(make_item(2, 1, 1, 1, 60, 10, 0, 0, 4, 1, 0));
        send_item(make_item(6, 0, 1, 1, 0, 0, 0, 0, 6, 0, 1));
        // tie between idle cpus goes to the earlier one, later cluster ignored
        send_item(make_item(2, 1, 1, 1, 300, 1000, 200, 0, 0, 0, 0));
        send_item(make_item(3, 1, 1, 1, 200, 1000, 300, 0, 0, 1, 0));
        send_item(make_item(4, 1, 1, 1, 0, 1000, 0, 0, 4, 0, 0));
        send_item(make_item(5, 1, 1, 0, 0, 1000, 0, 0, 0, 1, 1));
        // busy fallback with a tie on the lowest need
        send_item(make_item(0, 1, 1, 0, 100, 4095, 200, 0, 3, 0, 0));
        send_item(make_item(1, 1, 1, 0, 100, 4095, 100, 0, 3, 0, 0));
        send_item(make_item(2, 1, 1, 0, 150, 4095, 50, 0, 3, 1, 0));
        send_item(make_item(3, 1, 1, 1, 0, 4095, 0, 0, 3, 0, 1));
        // floor at full scale still fits, all-max item overcaps
        send_item(make_item(6, 1, 1, 1, 0, 4095, 0, 4095, 0, 0, 0));
        send_item(make_item(7, 1, 1, 1, 4095, 4095, 4095, 4095, 0, 0, 1));
        // single skipped cpu: nothing found
        send_item(make_item(0, 0, 0, 0, 4095, 0, 4095, 4095, 7, 1, 1));
        // fitting busy cpu beats an overcap idle one
        send_item(make_item(1, 1, 1, 1, 500, 100, 0, 0, 2, 0, 0));
        send_item(make_item(2, 1, 1, 0, 10, 100, 0, 0, 2, 1, 1));
        drain_picks();

        // random requests, about one in seven broken
        while (items_sent < ITEM_TARGET) begin
            send_request($urandom_range(0, 6) == 0);
            if (!drained_mid && items_sent >= ITEM_TARGET / 2) begin
                drain_picks();
                drained_mid = 1'b1;
            end
        end

        drain_picks();
        repeat (8) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
